[src/bsp_pkg.sv]
// Shared types and defaults for the Bresenham step pulse generator.
// No dependencies.
package bsp_pkg;

  localparam int unsigned AXES_DEF      = 6;
  localparam int unsigned MAX_AMASS_DEF = 3;
  localparam int unsigned SEG_DEPTH_DEF = 6;
  localparam int unsigned OUT_AXES      = 6;
  localparam logic [2:0]  AXIS_COUNT_RST = 3'd6;

  typedef enum logic [1:0] {
    ACT_WR_AXIS = 2'd0,
    ACT_WR_HDR  = 2'd1,
    ACT_PUSH    = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic        slot_ok;
    logic [2:0]  slot;
    logic        axis_ok;
    logic [2:0]  axis;
    logic [31:0] data;
    logic [5:0]  dir;
    logic        rate;
    logic [15:0] seg_steps;
    logic [1:0]  level;
    logic [15:0] period;
    logic [15:0] spindle;
  } cmd_t;

endpackage

[src/bsp_if.sv]
// Handshake channels of the step pulse generator: input items, result items
// and the configuration write port. No dependencies.
interface bsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  block_slot;
  logic [2:0]  axis;
  logic [31:0] axis_steps;
  logic [31:0] event_count;
  logic [5:0]  dir_bits;
  logic        rate_adjusted;
  logic [15:0] seg_steps;
  logic [1:0]  seg_level;
  logic [15:0] seg_period;
  logic [15:0] seg_spindle;
  modport source (output valid, action, block_slot, axis, axis_steps, event_count,
                  dir_bits, rate_adjusted, seg_steps, seg_level, seg_period,
                  seg_spindle, input ready);
  modport sink (input valid, action, block_slot, axis, axis_steps, event_count,
                dir_bits, rate_adjusted, seg_steps, seg_level, seg_period,
                seg_spindle, output ready);
endinterface

interface bsp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  step_pulses;
  logic [5:0]  dir_out;
  logic [15:0] period_value;
  logic        period_load;
  logic [15:0] spindle_value;
  logic        spindle_load;
  logic        stopped;
  logic        segment_done;
  logic        push_dropped;
  modport source (output valid, step_pulses, dir_out, period_value, period_load,
                  spindle_value, spindle_load, stopped, segment_done, push_dropped,
                  input ready);
  modport sink (input valid, step_pulses, dir_out, period_value, period_load,
                spindle_value, spindle_load, stopped, segment_done, push_dropped,
                output ready);
endinterface

interface bsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] axis_count;
  modport source (output valid, axis_count, input ready);
  modport sink (input valid, axis_count, output ready);
endinterface

[src/bsp_front.sv]
// Front end: accepts input items, checks slot and axis ranges and packs a command.
// Depends on bsp_pkg and bsp_in_if.
module bsp_front #(
  parameter int unsigned AXES      = bsp_pkg::AXES_DEF,
  parameter int unsigned SEG_DEPTH = bsp_pkg::SEG_DEPTH_DEF
) (
  bsp_in_if.sink          in_ch,
  input  logic            q_ready,
  output logic            q_valid,
  output bsp_pkg::cmd_t   q_cmd
);
  import bsp_pkg::*;

  localparam int unsigned BLOCKS = SEG_DEPTH - 1;

  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid;

  always_comb begin
    q_cmd           = '0;
    q_cmd.action    = action_t'(in_ch.action);
    q_cmd.slot      = in_ch.block_slot;
    q_cmd.slot_ok   = {29'd0, in_ch.block_slot} < BLOCKS;
    q_cmd.axis      = in_ch.axis;
    q_cmd.axis_ok   = {29'd0, in_ch.axis} < AXES;
    q_cmd.data      = (action_t'(in_ch.action) == ACT_WR_AXIS) ? in_ch.axis_steps
                                                                : in_ch.event_count;
    q_cmd.dir       = in_ch.dir_bits;
    q_cmd.rate      = in_ch.rate_adjusted;
    q_cmd.seg_steps = in_ch.seg_steps;
    q_cmd.level     = in_ch.seg_level;
    q_cmd.period    = in_ch.seg_period;
    q_cmd.spindle   = in_ch.seg_spindle;
  end

endmodule

[src/bsp_queue.sv]
// Two-entry command queue between the front end and the step engine.
// Depends on bsp_pkg.
module bsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bsp_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bsp_pkg::cmd_t rd_cmd
);
  import bsp_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

endmodule

[src/bsp_back.sv]
// Step engine: block tables, segment FIFO, Bresenham counters and result register.
// Depends on bsp_pkg and bsp_out_if.
module bsp_back #(
  parameter int unsigned AXES      = bsp_pkg::AXES_DEF,
  parameter int unsigned MAX_AMASS = bsp_pkg::MAX_AMASS_DEF,
  parameter int unsigned SEG_DEPTH = bsp_pkg::SEG_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bsp_pkg::cmd_t cmd,
  input  logic [2:0]    axis_count,
  bsp_out_if.source     out_ch
);
  import bsp_pkg::*;

  localparam int unsigned BLOCKS = SEG_DEPTH - 1;
  localparam int unsigned BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned FW     = $clog2(SEG_DEPTH);
  localparam int unsigned EW     = 32 + MAX_AMASS;
  localparam int unsigned CW     = 33 + MAX_AMASS;
  localparam int unsigned PW     = (AXES > OUT_AXES) ? AXES : OUT_AXES;

  typedef struct packed {
    logic [15:0]   steps;
    logic [1:0]    level;
    logic [15:0]   period;
    logic [15:0]   spindle;
    logic [BW-1:0] slot;
  } seg_t;

  logic [EW-1:0] axis_tab  [AXES][BLOCKS];
  logic [EW-1:0] event_tab [BLOCKS];
  logic [5:0]    dir_tab   [BLOCKS];
  logic          rate_tab  [BLOCKS];
  seg_t          seg_mem   [SEG_DEPTH];

  logic [FW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r [AXES];
  logic [CW-1:0] cnt_nxt [AXES];
  logic [EW-1:0] inc_r [AXES];
  logic [EW-1:0] inc_nxt [AXES];
  logic [15:0]   ticks_r, ticks_nxt;
  logic          active_r, active_nxt;
  logic [BW-1:0] cur_r, cur_nxt;
  logic          seen_r, seen_nxt;
  logic [5:0]    pend_r, pend_nxt;
  logic [5:0]    dir_r, dir_nxt;
  logic          ovalid_r;
  logic [5:0]    o_steps_r, o_steps_nxt, o_dir_r, o_dir_nxt;
  logic [15:0]   o_per_r, o_per_nxt, o_spin_r, o_spin_nxt;
  logic          o_pl_r, o_pl_nxt, o_sl_r, o_sl_nxt, o_stop_r, o_stop_nxt;
  logic          o_done_r, o_done_nxt, o_drop_r, o_drop_nxt;

  logic          go, is_tick, fifo_empty, load, stop, reseed, done, push_ok;
  logic [FW-1:0] head_inc, tail_inc;
  logic [BW-1:0] slot_idx, b, cur_eff;
  logic [EW-1:0] ev;
  logic [15:0]   ticks_eff;
  logic [PW-1:0] bits;
  logic [CW-1:0] base [AXES];
  logic [EW-1:0] inc  [AXES];
  logic [CW-1:0] sum  [AXES];
  seg_t          ent;

  assign cmd_ready = !ovalid_r || out_ch.ready;
  assign go        = cmd_valid && cmd_ready;
  assign is_tick   = (cmd.action == ACT_TICK);
  assign slot_idx  = BW'(cmd.slot);
  assign head_inc  = (head_r == FW'(SEG_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == FW'(SEG_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign fifo_empty = (head_r == tail_r);
  assign ent       = seg_mem[tail_r];
  assign b         = ent.slot;
  assign load      = !active_r && !fifo_empty;
  assign stop      = !active_r && fifo_empty;
  assign reseed    = load && (!seen_r || cur_r != b);
  assign cur_eff   = load ? b : cur_r;
  assign ev        = event_tab[cur_eff];
  assign ticks_eff = load ? ent.steps : ticks_r;
  assign done      = !stop && (ticks_eff <= 16'd1);
  assign push_ok   = (cmd.action == ACT_PUSH) && cmd.slot_ok && (head_inc != tail_r);

  always_comb begin
    bits = '0;
    for (int a = 0; a < AXES; a++) begin
      base[a] = reseed ? CW'(ev >> 1) : cnt_r[a];
      inc[a]  = load ? (axis_tab[a][b] >> ent.level) : inc_r[a];
      sum[a]  = base[a] + CW'(inc[a]);
      cnt_nxt[a] = cnt_r[a];
      inc_nxt[a] = inc_r[a];
      if (4'(a) < {1'b0, axis_count}) begin
        if (sum[a] > CW'(ev)) begin
          bits[a]    = 1'b1;
          cnt_nxt[a] = sum[a] - CW'(ev);
        end else begin
          cnt_nxt[a] = sum[a];
        end
        inc_nxt[a] = inc[a];
      end
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    ticks_nxt   = ticks_r;
    active_nxt  = active_r;
    cur_nxt     = cur_r;
    seen_nxt    = seen_r;
    pend_nxt    = pend_r;
    dir_nxt     = dir_r;
    o_steps_nxt = '0;
    o_dir_nxt   = dir_r;
    o_per_nxt   = '0;
    o_spin_nxt  = '0;
    o_pl_nxt    = 1'b0;
    o_sl_nxt    = 1'b0;
    o_stop_nxt  = 1'b0;
    o_done_nxt  = 1'b0;
    o_drop_nxt  = 1'b0;
    case (cmd.action)
      ACT_PUSH: begin
        if (cmd.slot_ok) begin
          if (head_inc == tail_r) begin
            o_drop_nxt = 1'b1;
          end else begin
            head_nxt = head_inc;
          end
        end
      end
      ACT_TICK: begin
        o_steps_nxt = pend_r;
        if (stop) begin
          pend_nxt   = '0;
          o_stop_nxt = 1'b1;
          o_sl_nxt   = seen_r && rate_tab[cur_r];
        end else begin
          if (load) begin
            o_per_nxt  = ent.period;
            o_pl_nxt   = 1'b1;
            o_spin_nxt = ent.spindle;
            o_sl_nxt   = 1'b1;
            cur_nxt    = b;
            seen_nxt   = 1'b1;
            dir_nxt    = dir_tab[b];
          end
          pend_nxt = bits[5:0];
          if (done) begin
            ticks_nxt  = '0;
            active_nxt = 1'b0;
            tail_nxt   = tail_inc;
            o_done_nxt = 1'b1;
          end else begin
            ticks_nxt  = ticks_eff - 16'd1;
            active_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      ticks_r  <= '0;
      active_r <= 1'b0;
      cur_r    <= '0;
      seen_r   <= 1'b0;
      pend_r   <= '0;
      dir_r    <= '0;
      ovalid_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        cnt_r[a] <= '0;
        inc_r[a] <= '0;
      end
    end else begin
      if (go) begin
        head_r <= head_nxt;
        if (is_tick) begin
          tail_r   <= tail_nxt;
          ticks_r  <= ticks_nxt;
          active_r <= active_nxt;
          cur_r    <= cur_nxt;
          seen_r   <= seen_nxt;
          pend_r   <= pend_nxt;
          dir_r    <= dir_nxt;
          if (!stop) begin
            for (int a = 0; a < AXES; a++) begin
              cnt_r[a] <= cnt_nxt[a];
              inc_r[a] <= inc_nxt[a];
            end
          end
        end
      end
      if (go) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      o_steps_r <= o_steps_nxt;
      o_dir_r   <= o_dir_nxt;
      o_per_r   <= o_per_nxt;
      o_spin_r  <= o_spin_nxt;
      o_pl_r    <= o_pl_nxt;
      o_sl_r    <= o_sl_nxt;
      o_stop_r  <= o_stop_nxt;
      o_done_r  <= o_done_nxt;
      o_drop_r  <= o_drop_nxt;
      if (cmd.action == ACT_WR_HDR && cmd.slot_ok) begin
        event_tab[slot_idx] <= EW'(cmd.data) << MAX_AMASS;
        dir_tab[slot_idx]   <= cmd.dir;
        rate_tab[slot_idx]  <= cmd.rate;
      end
      if (push_ok) begin
        seg_mem[head_r] <= '{steps: cmd.seg_steps, level: cmd.level, period: cmd.period,
                             spindle: cmd.spindle, slot: slot_idx};
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis_tab
    always_ff @(posedge clk) begin
      if (go && cmd.action == ACT_WR_AXIS && cmd.slot_ok && cmd.axis_ok &&
          cmd.axis == 3'(a)) begin
        axis_tab[a][slot_idx] <= EW'(cmd.data) << MAX_AMASS;
      end
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.step_pulses   = o_steps_r;
  assign out_ch.dir_out       = o_dir_r;
  assign out_ch.period_value  = o_per_r;
  assign out_ch.period_load   = o_pl_r;
  assign out_ch.spindle_value = o_spin_r;
  assign out_ch.spindle_load  = o_sl_r;
  assign out_ch.stopped       = o_stop_r;
  assign out_ch.segment_done  = o_done_r;
  assign out_ch.push_dropped  = o_drop_r;

endmodule

[src/bresenham_step_pulse_generator.sv]
// Top level of the multi-axis Bresenham step pulse generator.
// Depends on bsp_pkg, the channel interfaces, bsp_front, bsp_queue and bsp_back.
//
// One item (table write, segment push or tick) is taken per clock cycle while the
// queue has room; each gives exactly one result, registered in the queue and then
// in the result register, held there while out_ch stalls. The step engine updates
// the counters of axes below axis_count in parallel; a two-entry queue lets input
// flow while a result waits to be taken. Segment FIFO holds SEG_DEPTH-1 segments;
// axis_count must be written only while no items are in flight; not enforced here.
module bresenham_step_pulse_generator #(
  parameter int unsigned AXES      = bsp_pkg::AXES_DEF,
  parameter int unsigned MAX_AMASS = bsp_pkg::MAX_AMASS_DEF,
  parameter int unsigned SEG_DEPTH = bsp_pkg::SEG_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsp_in_if.sink     in_ch,
  bsp_out_if.source  out_ch,
  bsp_cfg_if.sink    cfg_ch
);
  import bsp_pkg::*;

  logic       f_valid, f_ready, q_valid, q_ready;
  cmd_t       f_cmd, q_cmd;
  logic [2:0] axis_count_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= AXIS_COUNT_RST;
    end else if (cfg_ch.valid) begin
      axis_count_r <= cfg_ch.axis_count;
    end
  end

  bsp_front #(.AXES(AXES), .SEG_DEPTH(SEG_DEPTH)) u_front (
    .in_ch   (in_ch),
    .q_ready (f_ready),
    .q_valid (f_valid),
    .q_cmd   (f_cmd)
  );

  bsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  bsp_back #(.AXES(AXES), .MAX_AMASS(MAX_AMASS), .SEG_DEPTH(SEG_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .axis_count (axis_count_r),
    .out_ch     (out_ch)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_cmd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |=> out_ch.valid)
    else $error("executed command gave no result");

  a_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stopped |-> !out_ch.period_load && !out_ch.segment_done)
    else $error("stop result also loads or finishes a segment");

endmodule
